// ===== src/ali_pkg.sv =====
// Package for the array list block: payload types, operation and status codes,
// and default sizes. No dependencies.
`default_nettype none

package ali_pkg;

  // Entry width and default storage depth
  localparam int DATA_W    = 32;
  localparam int DEPTH_DEF = 64;

  // Capacity register
  localparam int               CAP_W     = 7;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  // Operation codes
  localparam logic [1:0] FUNC_APPEND = 2'd0;
  localparam logic [1:0] FUNC_INSERT = 2'd1;
  localparam logic [1:0] FUNC_REMOVE = 2'd2;
  localparam logic [1:0] FUNC_READ   = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // Request payload
  typedef struct packed {
    logic [1:0]               func;
    logic signed [DATA_W-1:0] value;
    logic [5:0]               index;
  } req_t;

  // Result payload
  typedef struct packed {
    logic [1:0]               status;
    logic [6:0]               count;
    logic [6:0]               removed_count;
    logic signed [DATA_W-1:0] read_value;
  } rsp_t;

endpackage

`default_nettype wire

// ===== src/ali_chan_if.sv =====
// Valid/ready channel interface with source and sink modports.
// Payload type is a parameter; users pass types from ali_pkg.
`default_nettype none

interface ali_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/ali_mem.sv =====
// List storage: one write port and one read port, registered read data.
// Depends on ali_pkg for the entry width.
`default_nettype none

module ali_mem #(
  parameter int DEPTH = ali_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [AW-1:0]             waddr,
  input  wire logic [ali_pkg::DATA_W-1:0] wdata,
  input  wire logic [AW-1:0]             raddr,
  output logic      [ali_pkg::DATA_W-1:0] rdata
);

  logic [ali_pkg::DATA_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/ali_ctrl.sv =====
// Sequencer for the list operations: holds the live count, walks the storage
// one entry per cycle for insert shifts and remove compaction. Uses ali_pkg.
`default_nettype none

module ali_ctrl #(
  parameter int DEPTH = ali_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire ali_pkg::req_t              req_data,
  input  wire logic [ali_pkg::CAP_W-1:0]  capacity,
  input  wire logic                       out_free,
  output logic                            idle,
  output logic                            res_valid,
  output ali_pkg::rsp_t                   res_data,
  output logic                            mem_we,
  output logic      [AW-1:0]              mem_waddr,
  output logic      [ali_pkg::DATA_W-1:0] mem_wdata,
  output logic      [AW-1:0]              mem_raddr,
  input  wire logic [ali_pkg::DATA_W-1:0] mem_rdata
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > ali_pkg::CAP_W) ? CW : ali_pkg::CAP_W;
  localparam int IW = (CW > 6) ? CW : 6;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SHIFT = 6'b000010,
    S_PLACE = 6'b000100,
    S_RMV   = 6'b001000,
    S_READ  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t                      state, state_next;
  logic [CW-1:0]               live, live_next;
  logic [CW-1:0]               ptr, ptr_next;
  logic [CW-1:0]               kept, kept_next;
  logic [CW-1:0]               removed, removed_next;
  logic [ali_pkg::DATA_W-1:0]  val, val_next;
  logic [5:0]                  idx, idx_next;
  logic [1:0]                  status, status_next;
  logic [ali_pkg::DATA_W-1:0]  rd, rd_next;

  logic full;
  logic idx_gt_live;
  logic idx_eq_live;
  logic idx_ge_live;
  logic match;

  // List limit checks on the incoming request
  always_comb begin
    full = (XW'(live) >= XW'(capacity)) || (live == CW'(DEPTH));
    idx_gt_live = IW'(req_data.index) > IW'(live);
    idx_eq_live = IW'(req_data.index) == IW'(live);
    idx_ge_live = idx_gt_live || idx_eq_live;
  end

  // Shared equality compare for remove
  assign match = (mem_rdata == val);

  // Sequencer
  always_comb begin
    state_next   = state;
    live_next    = live;
    ptr_next     = ptr;
    kept_next    = kept;
    removed_next = removed;
    val_next     = val;
    idx_next     = idx;
    status_next  = status;
    rd_next      = rd;
    mem_we       = 1'b0;
    mem_waddr    = AW'(live);
    mem_wdata    = val;
    mem_raddr    = AW'(ptr);

    case (state)
      S_IDLE: begin
        if (start) begin
          val_next     = req_data.value;
          idx_next     = req_data.index;
          status_next  = ali_pkg::ST_OK;
          rd_next      = '0;
          removed_next = '0;
          kept_next    = '0;
          state_next   = S_DONE;
          case (req_data.func)
            ali_pkg::FUNC_APPEND: begin
              if (full) begin
                status_next = ali_pkg::ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = AW'(live);
                mem_wdata = req_data.value;
                live_next = live + CW'(1);
              end
            end
            ali_pkg::FUNC_INSERT: begin
              if (full) begin
                status_next = ali_pkg::ST_FULL;
              end else if (idx_gt_live) begin
                status_next = ali_pkg::ST_RANGE;
              end else if (idx_eq_live) begin
                mem_we    = 1'b1;
                mem_waddr = AW'(live);
                mem_wdata = req_data.value;
                live_next = live + CW'(1);
              end else begin
                // fetch the last live entry, then walk down
                mem_raddr  = AW'(live - CW'(1));
                ptr_next   = live;
                state_next = S_SHIFT;
              end
            end
            ali_pkg::FUNC_REMOVE: begin
              ptr_next = '0;
              if (live != '0) begin
                mem_raddr  = '0;
                state_next = S_RMV;
              end
            end
            default: begin
              if (idx_ge_live) begin
                status_next = ali_pkg::ST_RANGE;
              end else begin
                mem_raddr  = AW'(req_data.index);
                state_next = S_READ;
              end
            end
          endcase
        end
      end

      // move entry ptr-1 up to ptr, prefetch the one below
      S_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(ptr);
        mem_wdata = mem_rdata;
        if (IW'(ptr - CW'(1)) == IW'(idx)) begin
          state_next = S_PLACE;
        end else begin
          mem_raddr = AW'(ptr - CW'(2));
          ptr_next  = ptr - CW'(1);
        end
      end

      // drop the new value into the opened slot
      S_PLACE: begin
        mem_we     = 1'b1;
        mem_waddr  = AW'(idx);
        mem_wdata  = val;
        live_next  = live + CW'(1);
        state_next = S_DONE;
      end

      // compact: keep non-matching entries, count matches
      S_RMV: begin
        if (match) begin
          removed_next = removed + CW'(1);
        end else begin
          mem_we    = 1'b1;
          mem_waddr = AW'(kept);
          mem_wdata = mem_rdata;
          kept_next = kept + CW'(1);
        end
        if (ptr == live - CW'(1)) begin
          live_next  = kept_next;
          state_next = S_DONE;
        end else begin
          mem_raddr = AW'(ptr + CW'(1));
          ptr_next  = ptr + CW'(1);
        end
      end

      S_READ: begin
        rd_next    = mem_rdata;
        state_next = S_DONE;
      end

      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      live  <= '0;
    end else begin
      state <= state_next;
      live  <= live_next;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    ptr     <= ptr_next;
    kept    <= kept_next;
    removed <= removed_next;
    val     <= val_next;
    idx     <= idx_next;
    status  <= status_next;
    rd      <= rd_next;
  end

  // Result
  assign idle      = (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  always_comb begin
    res_data.status        = status;
    res_data.count         = 7'(live);
    res_data.removed_count = 7'(removed);
    res_data.read_value    = rd;
  end

endmodule

`default_nettype wire

// ===== src/array_list_insert_remove_top.sv =====
// Top level of the array list block: channels, capacity register, result
// register. Depends on ali_pkg, ali_chan_if, ali_mem and ali_ctrl.
//
// Usage:
//   req carries one operation (func, value, index); rsp returns one result
//   (status, count, removed_count, read_value) per request, in order.
//   cfg writes the capacity register; it is always ready and should only be
//   written while no request is in flight.
// Operations:
//   append and read access one entry, insert shifts the entries from index
//   up by one, remove compacts the list; failed or trivial cases do no walk.
//   The shift and compaction walks move one entry per cycle through the
//   single write port and single read port of the storage, with one request
//   in flight at a time.
// Reset: count and state clear, capacity returns to 64, no result pending.
//   Storage is not cleared; only entries written since are ever read.
// Stall: a result holds in the output register until rsp.ready; the next
//   request may be taken meanwhile and waits at its end for the slot to free.
`default_nettype none

module array_list_insert_remove_top #(
  parameter int DEPTH = ali_pkg::DEPTH_DEF
) (
  input wire logic  clk,
  input wire logic  rst,
  ali_chan_if.sink   req,
  ali_chan_if.source rsp,
  ali_chan_if.sink   cfg
);

  localparam int AW = $clog2(DEPTH);

  logic [ali_pkg::CAP_W-1:0]  capacity;
  logic                       idle;
  logic                       res_valid;
  ali_pkg::rsp_t              res_data;
  logic                       out_free;
  logic                       rsp_valid;
  ali_pkg::rsp_t              rsp_data;
  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [ali_pkg::DATA_W-1:0] mem_wdata;
  logic [AW-1:0]              mem_raddr;
  logic [ali_pkg::DATA_W-1:0] mem_rdata;

  // Capacity register
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= ali_pkg::CAP_RESET;
    end else if (cfg.valid) begin
      capacity <= cfg.data;
    end
  end

  assign req.ready = idle;
  assign out_free  = !rsp_valid || rsp.ready;

  ali_ctrl #(.DEPTH(DEPTH), .AW(AW)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (req.valid && idle),
    .req_data  (req.data),
    .capacity  (capacity),
    .out_free  (out_free),
    .idle      (idle),
    .res_valid (res_valid),
    .res_data  (res_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  ali_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Output register: load a finished result when the slot is free
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_free) begin
      rsp_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res_valid) begin
      rsp_data <= res_data;
    end
  end

  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

endmodule

`default_nettype wire

// ===== src/ali_chk.sv =====
// Port-level checks for the array list block, bound to the top level.
// Depends on ali_pkg for the result type and status codes.
`default_nettype none

module ali_chk (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          req_valid,
  input wire logic          req_ready,
  input wire logic          rsp_valid,
  input wire logic          rsp_ready,
  input wire ali_pkg::rsp_t rsp_data
);

  // Stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("result changed while stalled");

  // One request in flight: busy right after a request transfer
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");

  // Failed operations report nothing removed and no read data
  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.status != ali_pkg::ST_OK |->
      rsp_data.removed_count == '0 && rsp_data.read_value == '0)
    else $error("failed operation reported data");

  // Only defined status codes
  a_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_data.status == ali_pkg::ST_OK ||
                   rsp_data.status == ali_pkg::ST_FULL ||
                   rsp_data.status == ali_pkg::ST_RANGE))
    else $error("undefined status code");

  // Reset drops any pending result
  a_reset: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

endmodule

bind array_list_insert_remove_top ali_chk u_ali_chk (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_data  (rsp.data)
);

`default_nettype wire
